// ===== rtl/core/scd_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none

package scd_pkg;

  // Ring depth; one slot stays empty, so the queue holds QueueDepth-1 entries.
  localparam int unsigned QueueDepth = 256;
  localparam int unsigned PtrW       = $clog2(QueueDepth);

  localparam int unsigned CmdW    = 16;
  localparam int unsigned SampleW = 16;
  localparam int unsigned EntryW  = 16;
  localparam int unsigned AddrW   = 24;
  localparam int unsigned RegSelW = 3;

  localparam logic [11:0] SampleMask = 12'hFFF;

  // Output item width; result_t below lists its fields highest bit first.
  localparam int unsigned OutDataW = 56;

  typedef enum logic [3:0] {
    TgtPwmSel  = 4'd6,
    TgtPwmRaw  = 4'd7,
    TgtAddL    = 4'd11,
    TgtAddR    = 4'd12,
    TgtSubL    = 4'd13,
    TgtSubR    = 4'd14,
    TgtDeltaM  = 4'd15
  } target_e;

  localparam logic [RegSelW-1:0] RegLeft  = 3'd2;
  localparam logic [RegSelW-1:0] RegRight = 3'd3;
  localparam logic [RegSelW-1:0] RegMono  = 3'd4;

  typedef struct packed {
    logic [EntryW-1:0] queue_entry;
    logic              entry_valid;
    logic              sample_dropped;
    logic [7:0]        bus_data;
    logic              data_valid;
    logic [AddrW-1:0]  bus_addr;
    logic              addr_valid;
    logic              out_port;
  } result_t;

  function automatic logic [AddrW-1:0] target_addr(input logic [3:0] tgt);
    logic [AddrW-1:0] a;
    case (tgt)
      4'd1:    a = 24'hA04000;
      4'd2:    a = 24'hA04001;
      4'd3:    a = 24'hA04002;
      4'd4:    a = 24'hA04003;
      4'd5:    a = 24'hC00011;
      4'd8:    a = 24'hA12010;
      4'd9:    a = 24'hA12011;
      4'd10:   a = 24'hA12012;
      default: a = 24'hFF1000;
    endcase
    return a;
  endfunction

  function automatic logic [PtrW-1:0] ring_next(input logic [PtrW-1:0] p);
    return (p == PtrW'(QueueDepth - 1)) ? '0 : p + PtrW'(1);
  endfunction

endpackage

`default_nettype wire

// ===== rtl/core/sound_command_decoder_pwm_queue_unit.sv =====
// Sound command decoder with a PWM sample queue. Each input item is either a
// command word (tuser bit 0 low) or a request to pop one queued PWM entry
// (tuser bit 0 high), and each input item yields exactly one output item, in
// order. An item may be accepted every cycle unless the output stalls; its result
// passes through stage one, which holds the read of the queue RAM, and then the
// output register. The RAM has a single write port for pushes and a single
// registered read port for pops. Pointers, the register select, the high nibble
// and the eight last-sample values sit in flip-flops and are updated in the cycle
// the item is accepted, so a pop may directly follow the push that filled its slot.
// The queue holds up to 255 entries; a sample that finds it full is dropped and
// flagged. No clearing pass is needed after reset.
`timescale 1ns / 1ps
`default_nettype none

module sound_command_decoder_pwm_queue_unit
  import scd_pkg::*;
(
  input  wire logic                clk_i,
  input  wire logic                rst_ni,
  input  wire logic                s_axis_tvalid_i,
  output      logic                s_axis_tready_o,
  // command_word[15:0]
  input  wire logic [CmdW-1:0]     s_axis_tdata_i,
  // req_type[0], port[1]
  input  wire logic [1:0]          s_axis_tuser_i,
  output      logic                m_axis_tvalid_o,
  input  wire logic                m_axis_tready_i,
  // out_port[0], addr_valid[1], bus_addr[25:2], data_valid[26], bus_data[34:27],
  // sample_dropped[35], entry_valid[36], queue_entry[52:37], zero[55:53]
  output      logic [OutDataW-1:0] m_axis_tdata_o
);

  logic [EntryW-1:0]  queue_mem [QueueDepth];
  logic [EntryW-1:0]  rdata_q;

  logic [RegSelW-1:0] sel_q, sel_d;
  logic [3:0]         nib_q, nib_d;
  logic [SampleW-1:0] last_q [8];
  logic [PtrW-1:0]    head_q, head_d, tail_q, tail_d;

  logic    s1_valid_q, s1_hit_q;
  result_t s1_res_q, res_d, out_q, out_d;
  logic    out_valid_q;

  logic               accept, s1_go, deq_hit, push, push_ok;
  logic [CmdW-1:0]    cmd;
  logic [3:0]         tgt;
  logic [7:0]         dbyte;
  logic [RegSelW-1:0] push_reg;
  logic [SampleW-1:0] sample, last_rd;
  logic               full;

  assign s1_go           = !out_valid_q || m_axis_tready_i;
  assign s_axis_tready_o = !s1_valid_q || s1_go;
  assign accept          = s_axis_tvalid_i && s_axis_tready_o;

  assign cmd   = s_axis_tdata_i;
  assign tgt   = cmd[11:8];
  assign dbyte = {cmd[13:12], cmd[5:0]};
  assign full  = (ring_next(head_q) == tail_q);

  always_comb begin
    res_d    = '0;
    deq_hit  = 1'b0;
    push     = 1'b0;
    sel_d    = sel_q;
    nib_d    = nib_q;
    push_reg = sel_q;
    last_rd  = last_q[sel_q];
    sample   = {4'd0, nib_q, dbyte};
    if (s_axis_tuser_i[0]) begin
      deq_hit = (head_q != tail_q);
      res_d.entry_valid = deq_hit;
    end else if (cmd != '0) begin
      res_d.out_port   = s_axis_tuser_i[1];
      res_d.addr_valid = 1'b1;
      res_d.bus_addr   = target_addr(tgt);
      case (tgt)
        TgtPwmSel: begin
          sel_d = dbyte[6:4];
          nib_d = dbyte[3:0];
        end
        TgtPwmRaw: begin
          push = 1'b1;
        end
        TgtAddL, TgtSubL: begin
          push     = 1'b1;
          push_reg = RegLeft;
          last_rd  = last_q[RegLeft];
        end
        TgtAddR, TgtSubR: begin
          push     = 1'b1;
          push_reg = RegRight;
          last_rd  = last_q[RegRight];
        end
        TgtDeltaM: begin
          push     = 1'b1;
          push_reg = RegMono;
          last_rd  = last_q[RegMono];
        end
        default: begin
          res_d.data_valid = 1'b1;
          res_d.bus_data   = dbyte;
        end
      endcase
      if (push && (tgt != TgtPwmRaw)) begin
        sel_d = push_reg;
      end
      case (tgt)
        TgtAddL, TgtAddR: sample = last_rd + {8'd0, dbyte};
        TgtSubL, TgtSubR: sample = last_rd - {8'd0, dbyte};
        TgtDeltaM:        sample = last_rd + {{8{dbyte[7]}}, dbyte};
        default:          sample = {4'd0, nib_q, dbyte};
      endcase
      res_d.sample_dropped = push && full;
    end
  end

  assign push_ok = accept && push && !full;
  assign head_d  = push_ok ? ring_next(head_q) : head_q;
  assign tail_d  = (accept && deq_hit) ? ring_next(tail_q) : tail_q;

  // Queue RAM: one write port for pushes, one registered read port for pops.
  always_ff @(posedge clk_i) begin
    if (push_ok) begin
      queue_mem[head_q] <= {1'b0, push_reg, sample[11:0] & SampleMask};
    end
    if (accept && deq_hit) begin
      rdata_q <= queue_mem[tail_q];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sel_q  <= RegMono;
      nib_q  <= '0;
      head_q <= '0;
      tail_q <= '0;
      for (int i = 0; i < 8; i++) begin
        last_q[i] <= '0;
      end
    end else begin
      head_q <= head_d;
      tail_q <= tail_d;
      if (accept) begin
        sel_q <= sel_d;
        nib_q <= nib_d;
      end
      if (push_ok) begin
        last_q[push_reg] <= sample;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (s_axis_tready_o) begin
        s1_valid_q <= s_axis_tvalid_i;
      end
      if (s1_go) begin
        out_valid_q <= s1_valid_q;
      end
    end
  end

  always_comb begin
    out_d             = s1_res_q;
    out_d.queue_entry = s1_hit_q ? rdata_q : '0;
  end

  // The read data waits in rdata_q while stage one is stalled, since no new
  // read is issued until that stage moves on.
  always_ff @(posedge clk_i) begin
    if (accept) begin
      s1_res_q <= res_d;
      s1_hit_q <= deq_hit;
    end
    if (s1_go && s1_valid_q) begin
      out_q <= out_d;
    end
  end

  assign m_axis_tvalid_o = out_valid_q;
  assign m_axis_tdata_o  = {3'd0, out_q};

endmodule

`default_nettype wire

// ===== rtl/core/scd_checker.sv =====
`timescale 1ns / 1ps
`default_nettype none

module scd_checker
  import scd_pkg::*;
(
  input wire logic                clk_i,
  input wire logic                rst_ni,
  input wire logic                m_axis_tvalid_o,
  input wire logic                m_axis_tready_i,
  input wire logic [OutDataW-1:0] m_axis_tdata_o
);

  // A stalled output item keeps its contents.
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o && !m_axis_tready_i |=> m_axis_tvalid_o && $stable(m_axis_tdata_o))
    else $error("output item changed while stalled");

  // Bus data only accompanies a bus address.
  a_data_addr: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o && m_axis_tdata_o[26] |-> m_axis_tdata_o[1])
    else $error("data_valid without addr_valid");

  // A popped entry never comes with a command result.
  a_pop_excl: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o && m_axis_tdata_o[36] |-> !m_axis_tdata_o[1] && !m_axis_tdata_o[35])
    else $error("entry_valid mixed with a command result");

  // A dropped sample comes from a PWM target, which takes no data byte.
  a_drop_pwm: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o && m_axis_tdata_o[35] |-> m_axis_tdata_o[1] && !m_axis_tdata_o[26])
    else $error("sample_dropped on a non-PWM target");

  // A queue entry is only nonzero when an entry was returned.
  a_entry_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o && !m_axis_tdata_o[36] |-> m_axis_tdata_o[52:37] == '0)
    else $error("queue_entry nonzero without entry_valid");

endmodule

bind sound_command_decoder_pwm_queue_unit scd_checker u_scd_checker (
  .clk_i           (clk_i),
  .rst_ni          (rst_ni),
  .m_axis_tvalid_o (m_axis_tvalid_o),
  .m_axis_tready_i (m_axis_tready_i),
  .m_axis_tdata_o  (m_axis_tdata_o)
);

`default_nettype wire

// ===== tb/sound_command_decoder_pwm_queue_unit_test.sv =====
`timescale 1ns / 1ps

module sound_command_decoder_pwm_queue_unit_test;
  import scd_pkg::*;

  localparam int unsigned CycleLimit  = 60000;
  localparam int unsigned DrainCycles = 20;
  localparam int unsigned NumDirected = 24;

  // Bus address of each target, indexed by bits 11:8 of the command word.
  localparam logic [AddrW-1:0] BusAddrMap [16] = '{
    24'hFF1000, 24'hA04000, 24'hA04001, 24'hA04002,
    24'hA04003, 24'hC00011, 24'hFF1000, 24'hFF1000,
    24'hA12010, 24'hA12011, 24'hA12012, 24'hFF1000,
    24'hFF1000, 24'hFF1000, 24'hFF1000, 24'hFF1000
  };

  typedef struct {
    logic            req;
    logic            port;
    logic [CmdW-1:0] word;
    bit              typed;
    result_t         want;
  } directed_row_t;

  logic                clk_i = 1'b0;
  logic                rst_ni = 1'b0;
  logic                s_axis_tvalid_i = 1'b0;
  logic                s_axis_tready_o;
  logic [CmdW-1:0]     s_axis_tdata_i = '0;
  logic [1:0]          s_axis_tuser_i = '0;
  logic                m_axis_tvalid_o;
  logic                m_axis_tready_i = 1'b0;
  logic [OutDataW-1:0] m_axis_tdata_o;

  sound_command_decoder_pwm_queue_unit DUT (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .s_axis_tvalid_i (s_axis_tvalid_i),
    .s_axis_tready_o (s_axis_tready_o),
    .s_axis_tdata_i  (s_axis_tdata_i),
    .s_axis_tuser_i  (s_axis_tuser_i),
    .m_axis_tvalid_o (m_axis_tvalid_o),
    .m_axis_tready_i (m_axis_tready_i),
    .m_axis_tdata_o  (m_axis_tdata_o)
  );

  always #1 clk_i = ~clk_i;

  int unsigned cycle_count = 0;
  int unsigned mismatches = 0;
  int unsigned items_sent = 0;
  int unsigned results_seen = 0;
  int unsigned entries_popped = 0;
  int unsigned samples_dropped = 0;
  bit          calm = 1'b0;

  // Shadow of the decoder state.
  logic [RegSelW-1:0] pwm_sel = RegMono;
  logic [3:0]         pwm_nibble = '0;
  logic [SampleW-1:0] chan_last [8] = '{default: '0};
  logic [EntryW-1:0]  ring [QueueDepth];
  logic [PtrW-1:0]    ring_wr = '0;
  logic [PtrW-1:0]    ring_rd = '0;
  result_t            pending_results [$];

  target_e pwm_targets [6] = '{TgtPwmRaw, TgtAddL, TgtAddR, TgtSubL, TgtSubR, TgtDeltaM};

  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CycleLimit) begin
      $display("Timed out after %0d cycles with %0d results outstanding.",
               cycle_count, pending_results.size());
      $display("CHECKS FAILED");
      $finish;
    end
  end

  // The pointers are exactly PtrW bits wide, so they wrap at the ring depth on their own.
  function automatic logic store_sample(input logic [SampleW-1:0] s);
    if (PtrW'(ring_wr + 1'b1) == ring_rd) begin
      return 1'b1;
    end
    ring[ring_wr] = {1'b0, pwm_sel, s[11:0]};
    ring_wr = ring_wr + 1'b1;
    chan_last[pwm_sel] = s;
    return 1'b0;
  endfunction

  function automatic result_t decode_item(input logic req, input logic port,
                                          input logic [CmdW-1:0] w);
    result_t    r;
    logic [3:0] tgt;
    logic [7:0] d;
    r = '0;
    tgt = w[11:8];
    d = {w[13:12], w[5:0]};
    if (req) begin
      if (ring_wr != ring_rd) begin
        r.entry_valid = 1'b1;
        r.queue_entry = ring[ring_rd];
        ring_rd = ring_rd + 1'b1;
      end
    end else if (w != '0) begin
      r.out_port = port;
      r.addr_valid = 1'b1;
      r.bus_addr = BusAddrMap[tgt];
      case (tgt)
        TgtPwmSel: begin
          pwm_sel = d[6:4];
          pwm_nibble = d[3:0];
        end
        TgtPwmRaw: r.sample_dropped = store_sample({4'b0, pwm_nibble, d});
        TgtAddL: begin
          pwm_sel = RegLeft;
          r.sample_dropped = store_sample(chan_last[RegLeft] + SampleW'(d));
        end
        TgtAddR: begin
          pwm_sel = RegRight;
          r.sample_dropped = store_sample(chan_last[RegRight] + SampleW'(d));
        end
        TgtSubL: begin
          pwm_sel = RegLeft;
          r.sample_dropped = store_sample(chan_last[RegLeft] - SampleW'(d));
        end
        TgtSubR: begin
          pwm_sel = RegRight;
          r.sample_dropped = store_sample(chan_last[RegRight] - SampleW'(d));
        end
        TgtDeltaM: begin
          pwm_sel = RegMono;
          r.sample_dropped = store_sample(chan_last[RegMono] + {{8{d[7]}}, d});
        end
        default: begin
          r.data_valid = 1'b1;
          r.bus_data = d;
        end
      endcase
    end
    return r;
  endfunction

  task automatic offer_item(input logic req, input logic port, input logic [CmdW-1:0] word,
                            input bit typed, input result_t want);
    int unsigned gap;
    result_t     r;
    gap = calm ? 0 : $urandom_range(0, 5);
    if (gap != 0) begin
      s_axis_tvalid_i <= 1'b0;
      s_axis_tdata_i <= CmdW'($urandom);
      repeat (gap) @(posedge clk_i);
    end
    s_axis_tvalid_i <= 1'b1;
    s_axis_tdata_i <= word;
    s_axis_tuser_i <= {port, req};
    @(negedge clk_i);
    while (s_axis_tready_o !== 1'b1) @(negedge clk_i);
    @(posedge clk_i);
    r = decode_item(req, port, word);
    pending_results.push_back(typed ? want : r);
    items_sent++;
  endtask

  task automatic send_random(input int unsigned deq_pct, input int unsigned pwm_pct);
    logic [CmdW-1:0] word;
    logic [3:0]      tgt;
    logic            req;
    int unsigned     pick;
    if ($urandom_range(0, 29) == 0) calm = !calm;
    word = CmdW'($urandom);
    req = ($urandom_range(0, 99) < deq_pct);
    if (!req) begin
      pick = $urandom_range(0, 99);
      if (pick < pwm_pct) begin
        word[11:8] = pwm_targets[$urandom_range(0, 5)];
      end else begin
        pick = $urandom_range(0, 99);
        if (pick < 30) begin
          word[11:8] = TgtPwmSel;
        end else if (pick < 70) begin
          do tgt = 4'($urandom);
          while (tgt inside {TgtPwmSel, TgtPwmRaw, TgtAddL, TgtAddR, TgtSubL, TgtSubR,
                             TgtDeltaM});
          word[11:8] = tgt;
        end else if (pick < 80) begin
          word = '0;
        end
        // Otherwise the fully random word stands.
      end
    end
    offer_item(req, 1'($urandom), word, 1'b0, '0);
  endtask

  task automatic check_field(input string name, input logic [AddrW-1:0] want,
                             input logic [AddrW-1:0] got);
    if (got !== want) begin
      $error("%s mismatch: expected 0x%0h, got 0x%0h", name, want, got);
      mismatches++;
    end
  endtask

  initial begin : result_monitor
    int unsigned stall;
    result_t     got;
    result_t     want;
    wait (rst_ni === 1'b1);
    @(posedge clk_i);
    forever begin
      stall = calm ? 0 : $urandom_range(0, 5);
      if (stall != 0) begin
        m_axis_tready_i <= 1'b0;
        repeat (stall) @(posedge clk_i);
      end
      m_axis_tready_i <= 1'b1;
      @(negedge clk_i);
      while (m_axis_tvalid_o !== 1'b1) @(negedge clk_i);
      got = result_t'(m_axis_tdata_o[$bits(result_t)-1:0]);
      results_seen++;
      if (pending_results.size() == 0) begin
        $error("Result item 0x%0h arrived with nothing expected", m_axis_tdata_o);
        mismatches++;
      end else begin
        want = pending_results.pop_front();
        check_field("out_port", AddrW'(want.out_port), AddrW'(got.out_port));
        check_field("addr_valid", AddrW'(want.addr_valid), AddrW'(got.addr_valid));
        check_field("bus_addr", want.bus_addr, got.bus_addr);
        check_field("data_valid", AddrW'(want.data_valid), AddrW'(got.data_valid));
        check_field("bus_data", AddrW'(want.bus_data), AddrW'(got.bus_data));
        check_field("sample_dropped", AddrW'(want.sample_dropped),
                    AddrW'(got.sample_dropped));
        check_field("entry_valid", AddrW'(want.entry_valid), AddrW'(got.entry_valid));
        check_field("queue_entry", AddrW'(want.queue_entry), AddrW'(got.queue_entry));
        check_field("padding", '0, AddrW'(m_axis_tdata_o[OutDataW-1:$bits(result_t)]));
        if (want.entry_valid) entries_popped++;
        if (want.sample_dropped) samples_dropped++;
      end
      @(posedge clk_i);
    end
  end

  initial begin : stimulus
    directed_row_t directed_rows [NumDirected];
    directed_rows = '{
      // Pop from the empty queue right after reset; port and word are ignored.
      '{1'b1, 1'b1, 16'hFFFF, 1'b1, '0},
      // A zero command word does nothing.
      '{1'b0, 1'b1, 16'h0000, 1'b1, '0},
      '{1'b0, 1'b0, 16'h303F, 1'b1,
        '{addr_valid: 1'b1, bus_addr: 24'hFF1000, data_valid: 1'b1, bus_data: 8'hFF,
          default: '0}},
      '{1'b0, 1'b1, 16'h0100, 1'b1,
        '{out_port: 1'b1, addr_valid: 1'b1, bus_addr: 24'hA04000, data_valid: 1'b1,
          default: '0}},
      '{1'b0, 1'b0, 16'hC2C0, 1'b0, '0},
      '{1'b0, 1'b1, 16'h053F, 1'b1,
        '{out_port: 1'b1, addr_valid: 1'b1, bus_addr: 24'hC00011, data_valid: 1'b1,
          bus_data: 8'h3F, default: '0}},
      '{1'b0, 1'b0, 16'hC8D5, 1'b0, '0},
      '{1'b0, 1'b1, 16'h3AC0, 1'b0, '0},
      // Select register 7 with a high nibble of all ones.
      '{1'b0, 1'b0, 16'h367F, 1'b1,
        '{addr_valid: 1'b1, bus_addr: 24'hFF1000, default: '0}},
      '{1'b0, 1'b1, 16'h37FF, 1'b0, '0},
      '{1'b0, 1'b0, 16'h0B3F, 1'b0, '0},
      // Subtracting more than the last left value wraps below zero.
      '{1'b0, 1'b1, 16'h3D00, 1'b0, '0},
      '{1'b0, 1'b0, 16'h0C01, 1'b0, '0},
      '{1'b0, 1'b1, 16'h3EFF, 1'b0, '0},
      '{1'b0, 1'b0, 16'h0F01, 1'b0, '0},
      // Negative signed delta on the mono channel.
      '{1'b0, 1'b1, 16'h3F00, 1'b0, '0},
      '{1'b0, 1'b1, 16'h0600, 1'b1,
        '{out_port: 1'b1, addr_valid: 1'b1, bus_addr: 24'hFF1000, default: '0}},
      '{1'b0, 1'b0, 16'hC712, 1'b0, '0},
      '{1'b1, 1'b0, 16'h0000, 1'b1,
        '{entry_valid: 1'b1, queue_entry: 16'h7FFF, default: '0}},
      '{1'b1, 1'b1, 16'hFFFF, 1'b0, '0},
      '{1'b1, 1'b0, 16'h5A5A, 1'b0, '0},
      '{1'b1, 1'b1, 16'h0000, 1'b0, '0},
      '{1'b1, 1'b0, 16'hFFFF, 1'b0, '0},
      '{1'b1, 1'b1, 16'h1234, 1'b0, '0}
    };

    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    foreach (directed_rows[i]) begin
      offer_item(directed_rows[i].req, directed_rows[i].port, directed_rows[i].word,
                 directed_rows[i].typed, directed_rows[i].want);
    end

    repeat (80) send_random(35, 40);

    // Fill the ring to capacity, then keep pushing so that samples are dropped.
    while (PtrW'(ring_wr - ring_rd) != PtrW'(QueueDepth - 1)) send_random(0, 85);
    repeat (6) send_random(0, 100);

    // Hold off until the full queue has reported every result.
    s_axis_tvalid_i <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk_i);

    repeat (50) send_random(70, 40);

    s_axis_tvalid_i <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk_i);
    repeat (DrainCycles) @(posedge clk_i);

    $display("Sent %0d command and pop items, checked %0d results in %0d cycles.",
             items_sent, results_seen, cycle_count);
    $display("Queue entries popped: %0d, samples dropped on a full queue: %0d.",
             entries_popped, samples_dropped);
    if (mismatches == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule

// ===== sim.f =====
rtl/core/scd_pkg.sv
rtl/core/sound_command_decoder_pwm_queue_unit.sv
rtl/core/scd_checker.sv
tb/sound_command_decoder_pwm_queue_unit_test.sv
